// ----- rtl/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the host power sequencer
// Beat payloads, configuration layout, mode codes and fixed pulse lengths.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned INTERVAL_WIDTH_DEF = 10;
  localparam int unsigned CFG_DATA_W         = 10;
  localparam int unsigned CFG_INDEX_W        = 3;

  localparam logic [9:0] STARTUP_TIMEOUT_RST = 10'd600;
  localparam logic [9:0] HOLD_LIMIT_RST      = 10'd40;
  localparam logic [9:0] ACK_TIMEOUT_RST     = 10'd100;
  localparam logic [9:0] POWEROFF_DELAY_RST  = 10'd300;
  localparam logic [7:0] FLASH_PERIOD_RST    = 8'd2;
  localparam logic [7:0] DEBOUNCE_MS_RST     = 8'd50;

  localparam logic [7:0] PULSE_HIGH_MS = 8'd1;
  localparam logic [7:0] PULSE_LOW_MS  = 8'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STARTUP_TIMEOUT = 3'd0,
    CFG_HOLD_LIMIT      = 3'd1,
    CFG_ACK_TIMEOUT     = 3'd2,
    CFG_POWEROFF_DELAY  = 3'd3,
    CFG_FLASH_PERIOD    = 3'd4,
    CFG_DEBOUNCE_MS     = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MODE_OFF       = 4'd0,
    MODE_DEBOUNCE  = 4'd1,
    MODE_STARTING  = 4'd2,
    MODE_RUNNING   = 4'd3,
    MODE_ERROR     = 4'd4,
    MODE_HOLDCHECK = 4'd5,
    MODE_PULSEHIGH = 4'd6,
    MODE_PULSELOW  = 4'd7,
    MODE_AWAITACK  = 4'd8,
    MODE_OFFDELAY  = 4'd9,
    MODE_WAITREL   = 4'd10
  } mode_e;

  typedef struct packed {
    logic [9:0] startup_timeout;
    logic [9:0] hold_limit;
    logic [9:0] ack_timeout;
    logic [9:0] poweroff_delay;
    logic [7:0] flash_period;
    logic [7:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic tick_slow;
    logic tick_ms;
    logic button_low;
    logic comm_high;
  } in_t;

  typedef struct packed {
    logic       power_on;
    logic       led_green;
    logic       led_red;
    logic       comm_drive;
    logic       comm_value;
    logic [3:0] mode_code;
    logic       error_flag;
  } out_t;

endpackage

// ----- rtl/host_power_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// host_power_sequencer_unit: push-button power sequencer for a host
// Samples button, handshake line and tick strobes and drives the power
// switch, status LEDs and handshake line.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i (in_t)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (out_t)
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// Every input beat yields exactly one result beat. With the output not
// stalled, that beat is on the output in the cycle after the input is taken.
// One beat per cycle is sustained while the output is not stalled, set by the single state update.
// Reset loads the default timing values and puts the sequencer in off.
// A stalled output keeps its beat, and one more input beat is taken into the
// skid stage. in_stall_o then stays high until the output takes a beat, and
// it falls in the cycle after that.
// ----------------------------------------------------------------------------
module host_power_sequencer_unit #(
  parameter int unsigned INTERVAL_WIDTH = hps_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hps_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hps_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [hps_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hps_pkg::*;

  cfg_t cfg;
  out_t res;
  logic full, step;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  hps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hps_core #(
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  hps_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/hps_cfg.sv -----
// ----------------------------------------------------------------------------
// hps_cfg: configuration register file
// Six write-only timing registers, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
module hps_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hps_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output hps_pkg::cfg_t                   cfg_o
);
  import hps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STARTUP_TIMEOUT: cfg_d.startup_timeout = cfg_data_i[9:0];
        CFG_HOLD_LIMIT:      cfg_d.hold_limit      = cfg_data_i[9:0];
        CFG_ACK_TIMEOUT:     cfg_d.ack_timeout     = cfg_data_i[9:0];
        CFG_POWEROFF_DELAY:  cfg_d.poweroff_delay  = cfg_data_i[9:0];
        CFG_FLASH_PERIOD:    cfg_d.flash_period    = cfg_data_i[7:0];
        CFG_DEBOUNCE_MS:     cfg_d.debounce_ms     = cfg_data_i[7:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_timeout <= STARTUP_TIMEOUT_RST;
      cfg_q.hold_limit      <= HOLD_LIMIT_RST;
      cfg_q.ack_timeout     <= ACK_TIMEOUT_RST;
      cfg_q.poweroff_delay  <= POWEROFF_DELAY_RST;
      cfg_q.flash_period    <= FLASH_PERIOD_RST;
      cfg_q.debounce_ms     <= DEBOUNCE_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/hps_core.sv -----
// ----------------------------------------------------------------------------
// hps_core: sequencer state and next-state logic
// Updates timers, mode and drive registers once per accepted beat and
// presents the new output values as the result of that beat.
// ----------------------------------------------------------------------------
module hps_core #(
  parameter int unsigned INTERVAL_WIDTH = hps_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  hps_pkg::in_t  in_i,
  input  hps_pkg::cfg_t cfg_i,
  output hps_pkg::out_t res_o
);
  import hps_pkg::*;

  localparam int unsigned LW = (INTERVAL_WIDTH > 10) ? INTERVAL_WIDTH : 10;
  localparam logic [LW-1:0] IV_MAX = LW'((1 << INTERVAL_WIDTH) - 1);

  function automatic logic [INTERVAL_WIDTH-1:0] sat_load(input logic [9:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    if (ext > IV_MAX) begin
      sat_load = INTERVAL_WIDTH'(IV_MAX);
    end else begin
      sat_load = INTERVAL_WIDTH'(ext);
    end
  endfunction

  mode_e                     mode_q, mode_d, resume_q, resume_d;
  logic [INTERVAL_WIDTH-1:0] iv_q, iv_d, iv_dec;
  logic [7:0]                fl_q, fl_d, fl_dec;
  logic [7:0]                ms_q, ms_d, ms_dec;
  logic                      fault_q, fault_d;
  logic                      red_q, red_d;
  logic                      green_q, green_d;
  logic                      sw_q, sw_d;
  logic                      drive_q, drive_d;
  logic                      val_q, val_d;
  logic                      btn_prev_q;
  logic                      btn, comm, btn_edge, ms_run;

  assign btn      = in_i.button_low;
  assign comm     = in_i.comm_high;
  assign btn_edge = btn != btn_prev_q;
  assign ms_run   = (mode_q == MODE_DEBOUNCE) || (mode_q == MODE_PULSEHIGH) ||
                    (mode_q == MODE_PULSELOW);

  always_comb begin
    iv_dec = iv_q;
    fl_dec = fl_q;
    ms_dec = ms_q;
    if (in_i.tick_slow && (iv_q != '0)) iv_dec = iv_q - 1'b1;
    if (in_i.tick_slow && (fl_q != '0)) fl_dec = fl_q - 8'd1;
    if (in_i.tick_ms && (ms_q != '0) && ms_run) ms_dec = ms_q - 8'd1;
  end

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_OFF, MODE_RUNNING, MODE_ERROR: begin
        if (btn_edge) mode_d = MODE_DEBOUNCE;
      end
      MODE_DEBOUNCE: begin
        if (ms_dec == '0) begin
          if (!btn) begin
            mode_d = resume_q;
          end else if ((resume_q == MODE_RUNNING) || (resume_q == MODE_ERROR)) begin
            mode_d = MODE_HOLDCHECK;
          end else begin
            mode_d = MODE_STARTING;
          end
        end
      end
      MODE_STARTING: begin
        if (!comm) begin
          mode_d = MODE_RUNNING;
        end else if (iv_dec == '0) begin
          mode_d = MODE_ERROR;
        end
      end
      MODE_HOLDCHECK: begin
        if (btn) begin
          if (iv_dec == '0) mode_d = MODE_WAITREL;
        end else if (fault_q) begin
          mode_d = MODE_ERROR;
        end else begin
          mode_d = MODE_PULSEHIGH;
        end
      end
      MODE_PULSEHIGH: begin
        if (ms_dec == '0) mode_d = MODE_PULSELOW;
      end
      MODE_PULSELOW: begin
        if (ms_dec == '0) mode_d = MODE_AWAITACK;
      end
      MODE_AWAITACK: begin
        if (!comm) begin
          mode_d = MODE_OFFDELAY;
        end else if (iv_dec == '0) begin
          mode_d = MODE_ERROR;
        end
      end
      MODE_OFFDELAY: begin
        if (iv_dec == '0) mode_d = MODE_OFF;
      end
      MODE_WAITREL: begin
        if (!btn) mode_d = MODE_OFF;
      end
      default: mode_d = MODE_OFF;
    endcase
  end

  // Timers and drive registers.
  always_comb begin
    resume_d = resume_q;
    iv_d     = iv_dec;
    fl_d     = fl_dec;
    ms_d     = ms_dec;
    fault_d  = fault_q;
    red_d    = red_q;
    green_d  = green_q;
    sw_d     = sw_q;
    drive_d  = drive_q;
    val_d    = val_q;
    case (mode_q)
      MODE_OFF, MODE_RUNNING, MODE_ERROR: begin
        if (btn_edge) begin
          resume_d = mode_q;
          ms_d     = cfg_i.debounce_ms;
        end else if ((mode_q == MODE_ERROR) && (fl_dec == '0)) begin
          red_d = ~red_q;
          fl_d  = cfg_i.flash_period;
        end
      end
      MODE_DEBOUNCE: begin
        if ((ms_dec == '0) && btn) begin
          if ((resume_q == MODE_RUNNING) || (resume_q == MODE_ERROR)) begin
            iv_d    = sat_load(cfg_i.hold_limit);
            red_d   = 1'b1;
            green_d = 1'b0;
          end else begin
            fault_d = 1'b0;
            sw_d    = 1'b1;
            green_d = 1'b1;
            red_d   = 1'b1;
            iv_d    = sat_load(cfg_i.startup_timeout);
          end
        end
      end
      MODE_STARTING: begin
        if (!comm) begin
          red_d = 1'b0;
        end else if (iv_dec == '0) begin
          fault_d = 1'b1;
          green_d = 1'b0;
        end
      end
      MODE_HOLDCHECK: begin
        if (btn) begin
          if (fl_dec == '0) begin
            red_d   = ~red_q;
            green_d = ~green_q;
            fl_d    = cfg_i.flash_period;
          end
          if (iv_dec == '0) begin
            fault_d = 1'b0;
            red_d   = 1'b1;
            green_d = 1'b0;
            sw_d    = 1'b0;
            drive_d = 1'b0;
            val_d   = 1'b0;
          end
        end else if (fault_q) begin
          red_d   = 1'b1;
          green_d = 1'b0;
        end else begin
          red_d   = 1'b1;
          green_d = 1'b0;
          drive_d = 1'b1;
          val_d   = 1'b1;
          ms_d    = PULSE_HIGH_MS;
        end
      end
      MODE_PULSEHIGH: begin
        if (ms_dec == '0) begin
          val_d = 1'b0;
          ms_d  = PULSE_LOW_MS;
        end
      end
      MODE_PULSELOW: begin
        if (ms_dec == '0) begin
          drive_d = 1'b0;
          val_d   = 1'b0;
          iv_d    = sat_load(cfg_i.ack_timeout);
        end
      end
      MODE_AWAITACK: begin
        if (!comm) begin
          green_d = 1'b1;
          iv_d    = sat_load(cfg_i.poweroff_delay);
        end else if (iv_dec == '0) begin
          red_d   = 1'b1;
          green_d = 1'b0;
          fault_d = 1'b1;
        end
      end
      MODE_OFFDELAY: begin
        if (iv_dec == '0) begin
          fault_d = 1'b0;
          red_d   = 1'b1;
          green_d = 1'b0;
          sw_d    = 1'b0;
          drive_d = 1'b0;
          val_d   = 1'b0;
        end
      end
      MODE_WAITREL: begin
        fault_d = fault_q;
      end
      default: begin
        fault_d = 1'b0;
        red_d   = 1'b1;
        green_d = 1'b0;
        sw_d    = 1'b0;
        drive_d = 1'b0;
        val_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      resume_q   <= MODE_OFF;
      iv_q       <= '0;
      fl_q       <= '0;
      ms_q       <= '0;
      fault_q    <= 1'b0;
      red_q      <= 1'b1;
      green_q    <= 1'b0;
      sw_q       <= 1'b0;
      drive_q    <= 1'b0;
      val_q      <= 1'b0;
      btn_prev_q <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      resume_q   <= resume_d;
      iv_q       <= iv_d;
      fl_q       <= fl_d;
      ms_q       <= ms_d;
      fault_q    <= fault_d;
      red_q      <= red_d;
      green_q    <= green_d;
      sw_q       <= sw_d;
      drive_q    <= drive_d;
      val_q      <= val_d;
      btn_prev_q <= btn;
    end
  end

  assign res_o.power_on   = sw_d;
  assign res_o.led_green  = green_d;
  assign res_o.led_red    = red_d;
  assign res_o.comm_drive = drive_d;
  assign res_o.comm_value = drive_d & val_d;
  assign res_o.mode_code  = mode_d;
  assign res_o.error_flag = fault_d;

endmodule

// ----- rtl/hps_obuf.sv -----
// ----------------------------------------------------------------------------
// hps_obuf: result register with skid stage
// Holds result beats for the output channel so that the input side keeps
// flowing for one beat while the output is stalled.
// ----------------------------------------------------------------------------
module hps_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hps_pkg::out_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hps_pkg::out_t out_data_o
);
  import hps_pkg::*;

  logic main_valid_q, skid_valid_q;
  out_t main_q, skid_q;
  logic pop;

  assign pop = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ----- bench/power_seq_check_pkg.sv -----
// ----------------------------------------------------------------------------
// power_seq_check_pkg: scoreboard for the host power sequencer bench
// Holds a beat-accurate copy of the sequencer state and its timing
// registers, predicts the pin levels for every accepted input beat, and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
package power_seq_check_pkg;
  import hps_pkg::*;

  localparam logic [INTERVAL_WIDTH_DEF-1:0] INTERVAL_MAX = '1;

  class sequencer_scoreboard;
    cfg_t                          regs;
    mode_e                         seq_mode;
    mode_e                         return_mode;
    logic [INTERVAL_WIDTH_DEF-1:0] interval_left;
    logic [7:0]                    flash_left;
    logic [7:0]                    ms_left;
    logic                          fault_seen;
    logic                          red_on;
    logic                          green_on;
    logic                          power_en;
    logic                          line_drv;
    logic                          line_lvl;
    logic                          btn_last;
    out_t                          expected_pins[$];
    int unsigned                   mismatches;
    int unsigned                   beats_checked;

    function new();
      regs.startup_timeout = STARTUP_TIMEOUT_RST;
      regs.hold_limit      = HOLD_LIMIT_RST;
      regs.ack_timeout     = ACK_TIMEOUT_RST;
      regs.poweroff_delay  = POWEROFF_DELAY_RST;
      regs.flash_period    = FLASH_PERIOD_RST;
      regs.debounce_ms     = DEBOUNCE_MS_RST;
      return_mode   = MODE_OFF;
      interval_left = '0;
      flash_left    = '0;
      ms_left       = '0;
      btn_last      = 1'b0;
      mismatches    = 0;
      beats_checked = 0;
      enter_off();
    endfunction

    function void enter_off();
      seq_mode   = MODE_OFF;
      fault_seen = 1'b0;
      red_on     = 1'b1;
      green_on   = 1'b0;
      power_en   = 1'b0;
      line_drv   = 1'b0;
      line_lvl   = 1'b0;
    endfunction

    function void arm_interval(logic [9:0] ticks);
      if (ticks > INTERVAL_MAX) begin
        interval_left = INTERVAL_MAX;
      end else begin
        interval_left = ticks;
      end
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STARTUP_TIMEOUT: regs.startup_timeout = value;
        CFG_HOLD_LIMIT:      regs.hold_limit      = value;
        CFG_ACK_TIMEOUT:     regs.ack_timeout     = value;
        CFG_POWEROFF_DELAY:  regs.poweroff_delay  = value;
        CFG_FLASH_PERIOD:    regs.flash_period    = value[7:0];
        CFG_DEBOUNCE_MS:     regs.debounce_ms     = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_pins.size();
    endfunction

    function void predict_pins(in_t beat);
      logic btn_changed;
      out_t pins;
      btn_changed = beat.button_low != btn_last;
      if (beat.tick_slow) begin
        if (interval_left != 0) interval_left--;
        if (flash_left != 0) flash_left--;
      end
      if (beat.tick_ms && ms_left != 0 && (seq_mode == MODE_DEBOUNCE ||
          seq_mode == MODE_PULSEHIGH || seq_mode == MODE_PULSELOW)) begin
        ms_left--;
      end
      case (seq_mode)
        MODE_OFF, MODE_RUNNING, MODE_ERROR: begin
          if (btn_changed) begin
            return_mode = seq_mode;
            ms_left     = regs.debounce_ms;
            seq_mode    = MODE_DEBOUNCE;
          end else if (seq_mode == MODE_ERROR && flash_left == 0) begin
            red_on     = ~red_on;
            flash_left = regs.flash_period;
          end
        end
        MODE_DEBOUNCE: begin
          if (ms_left == 0) begin
            if (!beat.button_low) begin
              seq_mode = return_mode;
            end else if (return_mode == MODE_RUNNING || return_mode == MODE_ERROR) begin
              arm_interval(regs.hold_limit);
              red_on   = 1'b1;
              green_on = 1'b0;
              seq_mode = MODE_HOLDCHECK;
            end else begin
              fault_seen = 1'b0;
              power_en   = 1'b1;
              green_on   = 1'b1;
              red_on     = 1'b1;
              arm_interval(regs.startup_timeout);
              seq_mode   = MODE_STARTING;
            end
          end
        end
        MODE_STARTING: begin
          if (!beat.comm_high) begin
            red_on   = 1'b0;
            seq_mode = MODE_RUNNING;
          end else if (interval_left == 0) begin
            fault_seen = 1'b1;
            green_on   = 1'b0;
            seq_mode   = MODE_ERROR;
          end
        end
        MODE_HOLDCHECK: begin
          if (beat.button_low) begin
            if (flash_left == 0) begin
              red_on     = ~red_on;
              green_on   = ~green_on;
              flash_left = regs.flash_period;
            end
            if (interval_left == 0) begin
              enter_off();
              seq_mode = MODE_WAITREL;
            end
          end else if (fault_seen) begin
            red_on   = 1'b1;
            green_on = 1'b0;
            seq_mode = MODE_ERROR;
          end else begin
            red_on   = 1'b1;
            green_on = 1'b0;
            line_drv = 1'b1;
            line_lvl = 1'b1;
            ms_left  = PULSE_HIGH_MS;
            seq_mode = MODE_PULSEHIGH;
          end
        end
        MODE_PULSEHIGH: begin
          if (ms_left == 0) begin
            line_lvl = 1'b0;
            ms_left  = PULSE_LOW_MS;
            seq_mode = MODE_PULSELOW;
          end
        end
        MODE_PULSELOW: begin
          if (ms_left == 0) begin
            line_drv = 1'b0;
            line_lvl = 1'b0;
            arm_interval(regs.ack_timeout);
            seq_mode = MODE_AWAITACK;
          end
        end
        MODE_AWAITACK: begin
          if (!beat.comm_high) begin
            green_on = 1'b1;
            arm_interval(regs.poweroff_delay);
            seq_mode = MODE_OFFDELAY;
          end else if (interval_left == 0) begin
            red_on     = 1'b1;
            green_on   = 1'b0;
            fault_seen = 1'b1;
            seq_mode   = MODE_ERROR;
          end
        end
        MODE_OFFDELAY: begin
          if (interval_left == 0) enter_off();
        end
        MODE_WAITREL: begin
          if (!beat.button_low) seq_mode = MODE_OFF;
        end
        default: enter_off();
      endcase
      btn_last = beat.button_low;

      pins.power_on   = power_en;
      pins.led_green  = green_on;
      pins.led_red    = red_on;
      pins.comm_drive = line_drv;
      pins.comm_value = line_drv & line_lvl;
      pins.mode_code  = seq_mode;
      pins.error_flag = fault_seen;
      expected_pins.push_back(pins);
    endfunction

    function string show(out_t p);
      return $sformatf("pwr=%b grn=%b red=%b drv=%b val=%b mode=%0d err=%b",
                       p.power_on, p.led_green, p.led_red, p.comm_drive,
                       p.comm_value, p.mode_code, p.error_flag);
    endfunction

    function void compare_pins(out_t got);
      out_t want;
      logic bad;
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with nothing pending: %s", show(got));
        return;
      end
      want = expected_pins.pop_front();
      bad = (got.power_on   !== want.power_on)   ||
            (got.led_green  !== want.led_green)  ||
            (got.led_red    !== want.led_red)    ||
            (got.comm_drive !== want.comm_drive) ||
            (got.comm_value !== want.comm_value) ||
            (got.mode_code  !== want.mode_code)  ||
            (got.error_flag !== want.error_flag);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Beat %0d mismatch: expected %s", beats_checked, show(want));
          $display("Beat %0d mismatch: actual   %s", beats_checked, show(got));
        end
      end
      beats_checked++;
    endfunction
  endclass

endpackage

// ----- bench/host_power_sequencer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// host_power_sequencer_unit_tb: self-checking bench for the power sequencer
// Drives directed and random pin samples through the valid/stall channel
// under several timing settings, with random input idle cycles and output stall
// cycles, and checks every result beat against the scoreboard prediction.
// ----------------------------------------------------------------------------
module host_power_sequencer_unit_tb;
  import hps_pkg::*;
  import power_seq_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   steady       = 1'b0;
  logic                   button_level = 1'b0;
  int unsigned            cycles       = 0;
  sequencer_scoreboard    sb;

  in_t zero_walk [18] = '{
    4'b0010, 4'b0010, 4'b0011, 4'b0011, 4'b1011, 4'b0001,
    4'b0101, 4'b0011, 4'b0011, 4'b1111, 4'b0001, 4'b0010,
    4'b0010, 4'b0000, 4'b0010, 4'b0010, 4'b0000, 4'b0100
  };

  host_power_sequencer_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.compare_pins(out_data);
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  task automatic send_beat(in_t beat);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_pins(beat);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(CFG_STARTUP_TIMEOUT, c.startup_timeout);
    write_reg(CFG_HOLD_LIMIT, c.hold_limit);
    write_reg(CFG_ACK_TIMEOUT, c.ack_timeout);
    write_reg(CFG_POWEROFF_DELAY, c.poweroff_delay);
    write_reg(CFG_FLASH_PERIOD, {2'b00, c.flash_period});
    write_reg(CFG_DEBOUNCE_MS, {2'b00, c.debounce_ms});
    cfg_we <= 1'b0;
  endtask

  task automatic drive_phase(int unsigned beats, int unsigned slow_pct, int unsigned ms_pct,
                             int unsigned flip_pct, int unsigned low_pct);
    in_t beat;
    for (int unsigned n = 0; n < beats; n++) begin
      if ($urandom_range(0, 99) < flip_pct) button_level = ~button_level;
      beat.tick_slow  = $urandom_range(0, 99) < slow_pct;
      beat.tick_ms    = $urandom_range(0, 99) < ms_pct;
      beat.button_low = ($urandom_range(0, 99) < 6) ? ($urandom_range(0, 1) == 1)
                                                    : button_level;
      beat.comm_high  = $urandom_range(0, 99) >= low_pct;
      send_beat(beat);
    end
    drain();
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(in_t'(4'b0000));
    send_beat(in_t'(4'b1111));
    send_beat(in_t'(4'b0101));
    send_beat(in_t'(4'b1010));
    drain();

    apply_settings('0);
    foreach (zero_walk[k]) send_beat(zero_walk[k]);
    drain();

    apply_settings('{10'd3, 10'd4, 10'd2, 10'd3, 8'd1, 8'd2});
    drive_phase(180, 30, 90, 5, 20);

    apply_settings('0);
    drive_phase(60, 50, 50, 10, 30);

    steady <= 1'b1;
    apply_settings('{10'd10, 10'd6, 10'd5, 10'd8, 8'd3, 8'd5});
    drive_phase(150, 25, 90, 4, 15);
    steady <= 1'b0;

    apply_settings('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255});
    drive_phase(40, 50, 50, 10, 50);

    apply_settings('{10'd1, 10'd2, 10'd1, 10'd1, 8'd0, 8'd1});
    drive_phase(150, 40, 95, 6, 25);

    c.startup_timeout = 10'($urandom_range(0, 15));
    c.hold_limit      = 10'($urandom_range(0, 15));
    c.ack_timeout     = 10'($urandom_range(0, 15));
    c.poweroff_delay  = 10'($urandom_range(0, 15));
    c.flash_period    = 8'($urandom_range(0, 3));
    c.debounce_ms     = 8'($urandom_range(0, 4));
    apply_settings(c);
    drive_phase(80, 30, 80, 8, 20);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hps_pkg.sv
rtl/hps_cfg.sv
rtl/hps_core.sv
rtl/hps_obuf.sv
rtl/host_power_sequencer_unit.sv
bench/power_seq_check_pkg.sv
bench/host_power_sequencer_unit_tb.sv
